// ----- rtl/core/sorted_key_table_defines.svh -----
// assertion macros shared by the checker of the sorted key table
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define SKT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SKT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/skt_pkg.sv -----
// types and constants of the sorted key table
package skt_pkg;

   localparam int OP_W      = 2;
   localparam int KEY_W     = 64;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;
   localparam int IDX_W     = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CMP    = 4'b0010,
      S_SEARCH = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
   } cell_cmd_type;

   // compare result of one cell against the request key
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

// ----- rtl/core/skt_req_if.sv -----
// request channel of the sorted key table
interface skt_req_if
   import skt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [KEY_W-1:0]     key;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, output op, output key, output payload, input ready);
   modport sink (input valid, input op, input key, input payload, output ready);
endinterface

// ----- rtl/core/skt_rsp_if.sv -----
// response channel of the sorted key table
interface skt_rsp_if
   import skt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [IDX_W-1:0]     index;
   logic [PAYLOAD_W-1:0] found_payload;
   logic [IDX_W-1:0]     count;

   modport source (output valid, output status, output index, output found_payload,
                   output count, input ready);
   modport sink (input valid, input status, input index, input found_payload,
                 input count, output ready);
endinterface

// ----- rtl/core/skt_cell.sv -----
// one table entry: holds key and payload, compares and shifts with its neighbours
module skt_cell
   import skt_pkg::*;
#(
   parameter int CELL_IDX = 0,
   parameter int AW       = 7,
   parameter int KW       = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [AW-1:0]        pos,
   input  logic [KW-1:0]        new_key,
   input  logic [PAYLOAD_W-1:0] new_payload,
   input  logic [KW-1:0]        left_key,
   input  logic [PAYLOAD_W-1:0] left_payload,
   input  logic [KW-1:0]        right_key,
   input  logic [PAYLOAD_W-1:0] right_payload,
   output logic [KW-1:0]        key_out,
   output logic [PAYLOAD_W-1:0] payload_out,
   output cell_flags_type       flags
);

   localparam logic [AW-1:0] MY_IDX = AW'(CELL_IDX);

   logic [KW-1:0]        key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   cell_flags_type       flags_ff, flags_in;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (cmd.ins && (MY_IDX == pos)) begin
         key_in     = new_key;
         payload_in = new_payload;
      end else if (cmd.ins && (MY_IDX > pos)) begin
         key_in     = left_key;
         payload_in = left_payload;
      end else if (cmd.del && (MY_IDX >= pos)) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
      flags_in.lt = key_ff < new_key;
      flags_in.eq = key_ff == new_key;
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign key_out     = key_ff;
   assign payload_out = payload_ff;
   assign flags       = flags_ff;

endmodule

// ----- rtl/core/sorted_key_table.sv -----
// sorted key table: a row of compare-and-shift cells with a binary search controller
//
//  channel | dir | handshake     | payload
//  req_if  | in  | valid / ready | op, key, payload
//  rsp_if  | out | valid / ready | status, index, found_payload, count
//
// a request passes from acceptance to response through a compare state, a search loop
// that halves the index range on each pass (skipped for a full-table insert or an unused
// op) and a shift state that also writes the response register
// one request at a time; the next is accepted while a response waits, and
// the shift stage holds until the response register is free
// synchronous reset clears control, count and the cell compare flags only; no clearing pass
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int DEPTH     = 128,
   parameter int KEY_BYTES = 8
) (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_if,
   skt_rsp_if.source rsp_if
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = 8 * KEY_BYTES;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [KW-1:0]        key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic [IDX_W-1:0]     rsp_count_ff, rsp_count_in;

   cell_cmd_type         cell_cmd;
   logic [KW-1:0]        key_chain [DEPTH];
   logic [PAYLOAD_W-1:0] payload_chain [DEPTH];
   cell_flags_type       flags_chain [DEPTH];
   logic [DEPTH-1:0]     lt_vec, eq_vec;
   logic [PAYLOAD_W-1:0] sel_payload;

   logic                 req_fire;
   logic                 out_free;
   logic [CW:0]          mid_sum;
   logic [AW-1:0]        mid;

   // ---------------------------------------------------------------- cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KW-1:0]        left_key, right_key;
      logic [PAYLOAD_W-1:0] left_payload, right_payload;

      if (g == 0) begin : g_first
         assign left_key     = key_ff;
         assign left_payload = payload_ff;
      end else begin : g_inner_l
         assign left_key     = key_chain[g-1];
         assign left_payload = payload_chain[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_key     = key_chain[g];
         assign right_payload = payload_chain[g];
      end else begin : g_inner_r
         assign right_key     = key_chain[g+1];
         assign right_payload = payload_chain[g+1];
      end

      skt_cell #(
         .CELL_IDX(g),
         .AW      (AW),
         .KW      (KW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cell_cmd),
         .pos          (pos_ff),
         .new_key      (key_ff),
         .new_payload  (payload_ff),
         .left_key     (left_key),
         .left_payload (left_payload),
         .right_key    (right_key),
         .right_payload(right_payload),
         .key_out      (key_chain[g]),
         .payload_out  (payload_chain[g]),
         .flags        (flags_chain[g])
      );

      assign lt_vec[g] = flags_chain[g].lt;
      assign eq_vec[g] = flags_chain[g].eq;
   end

   // payload of the selected entry, one-hot and-or over the row
   always_comb begin
      sel_payload = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pos_ff == AW'(i)) begin
            sel_payload = sel_payload | payload_chain[i];
         end
      end
   end

   // ------------------------------------------------------------ controller
   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // floor((lo + hi - 1) / 2), only used while lo < hi
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid     = AW'(mid_sum[CW:1]);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      payload_in     = payload_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      pos_in         = pos_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_count_in   = rsp_count_ff;
      cell_cmd       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_if.op;
               key_in     = req_if.key[KW-1:0];
               payload_in = req_if.payload;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            lo_in  = '0;
            hi_in  = count_ff;
            pos_in = '0;
            if (op_ff == OP_INSERT && count_ff == FULL_COUNT) begin
               res_status_in = ST_FULL;
               state_in      = S_RESULT;
            end else if (op_ff inside {OP_INSERT, OP_LOOKUP, OP_DELETE}) begin
               state_in = S_SEARCH;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESULT;
            end
         end
         S_SEARCH: begin
            if (lo_ff == hi_ff) begin
               // range empty: insert point found, or key absent
               if (op_ff == OP_INSERT) begin
                  res_status_in = ST_OK;
                  pos_in        = AW'(lo_ff);
               end else begin
                  res_status_in = ST_NOT_FOUND;
                  pos_in        = '0;
               end
               state_in = S_RESULT;
            end else if (op_ff != OP_INSERT && eq_vec[mid]) begin
               res_status_in = ST_OK;
               pos_in        = mid;
               state_in      = S_RESULT;
            end else if (lt_vec[mid]) begin
               lo_in = CW'(mid) + CW'(1);
            end else begin
               hi_in = CW'(mid);
            end
         end
         S_RESULT: begin
            if (out_free) begin
               if (res_status_ff == ST_OK && op_ff == OP_INSERT) begin
                  count_in     = count_ff + CW'(1);
                  cell_cmd.ins = 1'b1;
               end else if (res_status_ff == ST_OK && op_ff == OP_DELETE) begin
                  count_in     = count_ff - CW'(1);
                  cell_cmd.del = 1'b1;
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_index_in   = (res_status_ff == ST_OK) ? IDX_W'(pos_ff) : '0;
               rsp_payload_in = (res_status_ff == ST_OK && op_ff == OP_LOOKUP) ?
                                sel_payload : '0;
               rsp_count_in   = IDX_W'(count_in);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      payload_ff     <= payload_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      pos_ff         <= pos_in;
      res_status_ff  <= res_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.index         = rsp_index_ff;
   assign rsp_if.found_payload = rsp_payload_ff;
   assign rsp_if.count         = rsp_count_ff;

endmodule

// ----- rtl/core/skt_checker.sv -----
// port checker of the sorted key table and its bind
`include "sorted_key_table_defines.svh"

module skt_checker
   import skt_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [IDX_W-1:0]     rsp_index,
   input logic [PAYLOAD_W-1:0] rsp_found_payload,
   input logic [IDX_W-1:0]     rsp_count
);

   // a held response keeps its contents
   `SKT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_index, rsp_found_payload, rsp_count}), "response changed while stalled")

   `SKT_ASSERT_RST(a_rst_clear, reset |=> !rsp_valid, "response valid after reset")

   // a refused insert only happens on a full table and reports no position
   `SKT_ASSERT(a_full, rsp_valid && rsp_status == ST_FULL |-> rsp_index == '0 && rsp_found_payload == '0 && rsp_count == IDX_W'(DEPTH), "bad table full response")

   `SKT_ASSERT(a_miss, rsp_valid && rsp_status == ST_NOT_FOUND |-> rsp_index == '0 && rsp_found_payload == '0, "miss carries index or payload")

endmodule

bind sorted_key_table skt_checker #(
   .DEPTH(DEPTH)
) u_skt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_index        (rsp_if.index),
   .rsp_found_payload(rsp_if.found_payload),
   .rsp_count        (rsp_if.count)
);
